/* sv/u8d_pkg.sv */
package u8d_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int OUT_OFF_W   = 32;
    localparam int CP_W        = 21;
    localparam int BUF_DEPTH   = 4;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CW     = 3;

    // byte classes, worked out on entry
    typedef logic [2:0] cls_t;
    localparam cls_t CLS_ASCII = 3'd0;
    localparam cls_t CLS_LEAD2 = 3'd1;
    localparam cls_t CLS_LEAD3 = 3'd2;
    localparam cls_t CLS_LEAD4 = 3'd3;
    localparam cls_t CLS_CONT  = 3'd4;
    localparam cls_t CLS_BAD   = 3'd5;

    // result kinds
    typedef logic [2:0] kind_t;
    localparam kind_t KIND_CP         = 3'd0;
    localparam kind_t KIND_INCOMPLETE = 3'd1;
    localparam kind_t KIND_MISSING    = 3'd2;
    localparam kind_t KIND_OVERLONG   = 3'd3;
    localparam kind_t KIND_UNEXP_CONT = 3'd4;
    localparam kind_t KIND_BAD_LEAD   = 3'd5;

    localparam logic [CP_W-1:0] BOM_CP = 21'h00FEFF;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        cls_t       cls;
    } entry_t;

    typedef struct packed {
        kind_t                  kind;
        logic [CP_W-1:0]        cp;
        logic [OFFSET_BITS-1:0] off;
    } result_t;

    function automatic cls_t classify(input logic [7:0] b);
        cls_t c;
        if ((b & 8'h80) == 8'h00) begin
            c = CLS_ASCII;
        end else if ((b & 8'hE0) == 8'hC0) begin
            c = CLS_LEAD2;
        end else if ((b & 8'hF0) == 8'hE0) begin
            c = CLS_LEAD3;
        end else if ((b & 8'hF8) == 8'hF0) begin
            c = CLS_LEAD4;
        end else if ((b & 8'hC0) == 8'h80) begin
            c = CLS_CONT;
        end else begin
            c = CLS_BAD;
        end
        return c;
    endfunction

    // sequence length of a lead; 0 for bytes that cannot lead
    function automatic logic [2:0] lead_len(input cls_t c);
        logic [2:0] l;
        case (c)
            CLS_ASCII: l = 3'd1;
            CLS_LEAD2: l = 3'd2;
            CLS_LEAD3: l = 3'd3;
            CLS_LEAD4: l = 3'd4;
            default:   l = 3'd0;
        endcase
        return l;
    endfunction

endpackage

/* sv/u8d_front.sv */
module u8d_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_in_byte,
    input  logic            s_end_of_stream,
    output logic            q_valid,
    output u8d_pkg::entry_t q_entry,
    input  logic            q_pop
);
    import u8d_pkg::*;

    entry_t              entries_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]  count_reg, count_next;
    logic                push;
    logic                pop;

    assign s_ready = (count_reg != FIFO_CW'(FIFO_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = entries_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // classify on the way in so the decoder sees the class ready-made
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= '{data: s_in_byte, eos: s_end_of_stream,
                                         cls: classify(s_in_byte)};
        end
    end

endmodule

/* sv/u8d_back.sv */
module u8d_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  u8d_pkg::entry_t                q_entry,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_kind,
    output logic [u8d_pkg::CP_W-1:0]       m_code_point,
    output logic [u8d_pkg::OUT_OFF_W-1:0]  m_byte_offset,
    output logic                           m_last_result
);
    import u8d_pkg::*;

    // working buffer: waiting bytes plus the newly loaded one
    logic [7:0]             bytes_reg [BUF_DEPTH];
    logic [7:0]             bytes_next [BUF_DEPTH];
    cls_t                   cls_reg [BUF_DEPTH];
    cls_t                   cls_next [BUF_DEPTH];
    logic [2:0]             n_reg, n_next;
    logic                   busy_reg, busy_next;
    logic                   eos_reg, eos_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic                   start_reg, start_next;
    // one result held back until it is known whether another follows
    result_t                hold_reg, hold_next;
    logic                   hold_valid_reg, hold_valid_next;
    result_t                out_reg, out_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_valid_reg, out_valid_next;

    logic [2:0]             len;
    logic                   cont_ok;
    logic [CP_W-1:0]        cp_val;
    logic                   overlong;
    logic                   gen;
    kind_t                  kind;
    logic [2:0]             cons;
    logic                   bom;
    logic                   end_step;
    logic                   need_out;
    logic                   out_free;
    logic                   go;
    logic [2:0]             src;

    always_comb begin
        len     = lead_len(cls_reg[0]);
        cont_ok = (len < 3'd2 || cls_reg[1] == CLS_CONT)
               && (len < 3'd3 || cls_reg[2] == CLS_CONT)
               && (len < 3'd4 || cls_reg[3] == CLS_CONT);
        case (len)
            3'd1:    cp_val = {14'd0, bytes_reg[0][6:0]};
            3'd2:    cp_val = {10'd0, bytes_reg[0][4:0], bytes_reg[1][5:0]};
            3'd3:    cp_val = {5'd0, bytes_reg[0][3:0], bytes_reg[1][5:0],
                               bytes_reg[2][5:0]};
            3'd4:    cp_val = {bytes_reg[0][2:0], bytes_reg[1][5:0],
                               bytes_reg[2][5:0], bytes_reg[3][5:0]};
            default: cp_val = '0;
        endcase
        case (len)
            3'd2:    overlong = cp_val < 21'h80;
            3'd3:    overlong = cp_val < 21'h800;
            3'd4:    overlong = cp_val < 21'h10000;
            default: overlong = 1'b0;
        endcase
    end

    // one decode step per cycle on the lead at the head of the buffer, unless the output stalls
    always_comb begin
        gen      = 1'b0;
        kind     = KIND_CP;
        cons     = 3'd0;
        bom      = 1'b0;
        end_step = 1'b0;
        if (busy_reg) begin
            if (n_reg == 3'd0) begin
                end_step = 1'b1;
            end else if (cls_reg[0] == CLS_CONT) begin
                gen  = 1'b1;
                kind = KIND_UNEXP_CONT;
                cons = 3'd1;
            end else if (cls_reg[0] == CLS_BAD) begin
                gen  = 1'b1;
                kind = KIND_BAD_LEAD;
                cons = 3'd1;
            end else if (len > n_reg) begin
                if (!eos_reg) begin
                    end_step = 1'b1;
                end else begin
                    gen  = 1'b1;
                    kind = KIND_INCOMPLETE;
                    cons = 3'd1;
                end
            end else if (!cont_ok) begin
                gen  = 1'b1;
                kind = KIND_MISSING;
                cons = 3'd1;
            end else if (overlong) begin
                gen  = 1'b1;
                kind = KIND_OVERLONG;
                cons = 3'd1;
            end else if (start_reg && len == 3'd3 && cp_val == BOM_CP) begin
                bom  = 1'b1;
                cons = 3'd3;
            end else begin
                gen  = 1'b1;
                kind = KIND_CP;
                cons = len;
            end
        end
    end

    assign need_out = hold_valid_reg && (gen || end_step);
    assign out_free = !out_valid_reg || m_ready;
    assign go       = !need_out || out_free;

    always_comb begin
        src             = '0;
        bytes_next      = bytes_reg;
        cls_next        = cls_reg;
        n_next          = n_reg;
        busy_next       = busy_reg;
        eos_next        = eos_reg;
        off_next        = off_reg;
        start_next      = start_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        q_pop           = 1'b0;
        if (go) begin
            if (need_out) begin
                out_next       = hold_reg;
                out_last_next  = end_step;
                out_valid_next = 1'b1;
            end
            if (gen) begin
                hold_next       = '{kind: kind,
                                    cp: (kind == KIND_CP) ? cp_val : '0,
                                    off: off_reg};
                hold_valid_next = 1'b1;
                start_next      = 1'b0;
            end
            if (bom) begin
                start_next = 1'b0;
            end
            // drop consumed bytes from the head
            for (int i = 0; i < BUF_DEPTH; i++) begin
                src = 3'(i) + cons;
                if (src < 3'(BUF_DEPTH)) begin
                    bytes_next[i] = bytes_reg[src[1:0]];
                    cls_next[i]   = cls_reg[src[1:0]];
                end
            end
            n_next   = n_reg - cons;
            off_next = off_reg + OFFSET_BITS'(cons);
            if (end_step) begin
                hold_valid_next = 1'b0;
                busy_next       = 1'b0;
                if (eos_reg) begin
                    n_next     = 3'd0;
                    off_next   = '0;
                    start_next = 1'b1;
                end
            end
            // next word loads in the same cycle a step closes
            if ((!busy_reg || end_step) && q_valid) begin
                q_pop                  = 1'b1;
                bytes_next[n_next[1:0]] = q_entry.data;
                cls_next[n_next[1:0]]   = q_entry.cls;
                n_next                 = n_next + 3'd1;
                eos_next               = q_entry.eos;
                busy_next              = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg          <= '0;
            busy_reg       <= 1'b0;
            eos_reg        <= 1'b0;
            off_reg        <= '0;
            start_reg      <= 1'b1;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            n_reg          <= n_next;
            busy_reg       <= busy_next;
            eos_reg        <= eos_next;
            off_reg        <= off_next;
            start_reg      <= start_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg    <= bytes_next;
        cls_reg      <= cls_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = out_reg.kind;
    assign m_code_point  = out_reg.cp;
    assign m_byte_offset = OUT_OFF_W'(out_reg.off);
    assign m_last_result = out_last_reg;

endmodule

/* sv/utf8_decoder_with_error_report.sv */
// UTF-8 stream decoder with error reporting.
// Input channel (s_*): one byte per word, s_end_of_stream marks the final
// byte of a stream. Output channel (m_*): one result per word, a code point
// or an error kind, with the offset of its lead byte; m_last_result flags
// the last result caused by an input byte. Bytes that complete nothing
// yield no word at all.
//
// Structure: a 4-deep input queue classifies each byte as it enters; the
// decoder behind it holds up to three waiting bytes plus the new one and
// resolves one lead per cycle unless the output is stalled. Each result sits
// in a hold register until the decoder knows whether another follows, then
// moves to the output register.
//
// The decoder takes the next byte from the queue only once it has resolved
// every lead the previous byte allowed (results plus a dropped BOM).
// Reset (aresetn low, synchronous) empties queue and buffer and zeroes the
// offset. When m_ready is low the decoder stops once the output and hold
// registers are both full; the queue keeps taking up to four words.
module utf8_decoder_with_error_report (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_in_byte,
    input  logic                           s_end_of_stream,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_kind,
    output logic [u8d_pkg::CP_W-1:0]       m_code_point,
    output logic [u8d_pkg::OUT_OFF_W-1:0]  m_byte_offset,
    output logic                           m_last_result
);
    import u8d_pkg::*;

    logic   q_valid;
    entry_t q_entry;
    logic   q_pop;

    // front: queue + byte classification
    u8d_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_stream (s_end_of_stream),
        .q_valid         (q_valid),
        .q_entry         (q_entry),
        .q_pop           (q_pop)
    );

    // back: sequence decode, offset tracking, result staging
    u8d_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_code_point  (m_code_point),
        .m_byte_offset (m_byte_offset),
        .m_last_result (m_last_result)
    );

endmodule

/* sv/u8d_checker.sv */
module u8d_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [7:0]                     s_in_byte,
    input logic                           s_end_of_stream,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [2:0]                     m_kind,
    input logic [u8d_pkg::CP_W-1:0]       m_code_point,
    input logic [u8d_pkg::OUT_OFF_W-1:0]  m_byte_offset,
    input logic                           m_last_result
);
    import u8d_pkg::*;

    // errors never carry a value
    a_err_cp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_CP |-> m_code_point == '0)
        else $error("error result with nonzero code point");

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_code_point)
            && $stable(m_byte_offset) && $stable(m_last_result))
        else $error("result word changed while stalled");

    // a waiting input word keeps its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_in_byte) && $stable(s_end_of_stream))
        else $error("input word changed while waiting");

    // reset clears the output and opens the input queue
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("channels not idle after reset");

    // a freshly emptied decoder shows no result as reset is released
    a_rst_latency: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |-> !m_valid)
        else $error("result out of reset too early");

endmodule

bind utf8_decoder_with_error_report u8d_checker u_chk (.*);

/* tb/utf8_decoder_with_error_report_tb.sv */
`timescale 1ns / 1ps

module utf8_decoder_with_error_report_tb;

    import u8d_pkg::*;

    // Cycles without any word moving on either channel before we give up.
    // The slowest legal stretch is a sender gap plus the decode latency plus
    // up to four results each held off by a receiver stall.
    localparam int QUIET_LIMIT = 2000;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_in_byte       = 8'h00;
    logic                  s_end_of_stream = 1'b0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [2:0]            m_kind;
    logic [CP_W-1:0]       m_code_point;
    logic [OUT_OFF_W-1:0]  m_byte_offset;
    logic                  m_last_result;

    // One expected result word.
    typedef struct {
        kind_t                kind;
        logic [CP_W-1:0]      cp;
        logic [OUT_OFF_W-1:0] off;
        logic                 last;
    } exp_word_t;

    exp_word_t decoded_q[$];      // results still owed by the decoder, oldest first

    // Decoder state as the predictor sees it.
    logic [7:0]             held_bytes[3];
    int                     held_cnt    = 0;
    logic [OFFSET_BITS-1:0] lead_off    = '0;
    bit                     stream_head = 1'b1;

    int mismatches = 0;
    int words_sent = 0;
    int quiet_cycles = 0;

    // Idling knobs: idle_on gates all random gaps and stalls; the two
    // percentages set how often a burst starts on each side.
    bit idle_on   = 1'b1;
    int gap_pct   = 0;
    int stall_pct = 0;
    int stall_left = 0;

    utf8_decoder_with_error_report uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_code_point    (m_code_point),
        .m_byte_offset   (m_byte_offset),
        .m_last_result   (m_last_result)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    //------------------------------------------------------------------
    // Predictor: feed one accepted byte, queue the results it releases.
    // Waiting bytes plus the new one are scanned lead by lead; an error
    // drops only its lead byte, a good sequence consumes its full length.
    //------------------------------------------------------------------
    task automatic predict_decode(input logic [7:0] b, input logic eos);
        logic [7:0]  seq_buf[4];
        exp_word_t   found[4];
        int          n;
        int          pos;
        int          len;
        int          step;
        int          nfound;
        int          i;
        int unsigned b1;
        int unsigned cpv;
        int unsigned min_cp;
        kind_t       k;
        bit          emit;
        bit          ok;
        logic [63:0] off_wide;

        n = held_cnt;
        for (i = 0; i < n; i++) seq_buf[i] = held_bytes[i];
        seq_buf[n] = b;
        n++;
        pos = 0;
        nfound = 0;

        while (pos < n) begin
            b1 = 32'(seq_buf[pos]);
            if ((b1 & 'h80) == 'h00) len = 1;
            else if ((b1 & 'hE0) == 'hC0) len = 2;
            else if ((b1 & 'hF0) == 'hE0) len = 3;
            else if ((b1 & 'hF8) == 'hF0) len = 4;
            else len = 0;

            k = KIND_CP;
            cpv = 0;
            step = 1;
            emit = 1'b1;

            if (len == 0) begin
                k = ((b1 & 'hC0) == 'h80) ? KIND_UNEXP_CONT : KIND_BAD_LEAD;
            end else if (len > n - pos) begin
                // short sequence: wait for more, unless the stream ends here
                if (!eos) break;
                k = KIND_INCOMPLETE;
            end else begin
                ok = 1'b1;
                for (i = 1; i < len; i++)
                    if ((seq_buf[pos + i] & 8'hC0) != 8'h80) ok = 1'b0;
                if (!ok) begin
                    k = KIND_MISSING;
                end else begin
                    case (len)
                        1: begin cpv = b1;                 min_cp = 0;       end
                        2: begin cpv = (b1 & 'h1F) << 6;   min_cp = 'h80;    end
                        3: begin cpv = (b1 & 'h0F) << 12;  min_cp = 'h800;   end
                        default: begin cpv = (b1 & 'h07) << 18; min_cp = 'h10000; end
                    endcase
                    for (i = 1; i < len; i++)
                        cpv |= 32'(seq_buf[pos + i] & 8'h3F) << (6 * (len - 1 - i));
                    if (cpv < min_cp) begin
                        k = KIND_OVERLONG;
                        cpv = 0;
                    end else if (stream_head && len == 3 && cpv == 'hFEFF) begin
                        // byte order mark as first item: silently dropped
                        emit = 1'b0;
                        stream_head = 1'b0;
                        step = 3;
                    end else begin
                        step = len;
                    end
                end
            end

            if (emit) begin
                off_wide = 64'(lead_off);
                found[nfound].kind = k;
                found[nfound].cp   = cpv[CP_W-1:0];
                found[nfound].off  = off_wide[OUT_OFF_W-1:0];
                found[nfound].last = 1'b0;
                nfound++;
                stream_head = 1'b0;
            end
            lead_off += OFFSET_BITS'(step);
            pos += step;
        end

        held_cnt = n - pos;
        for (i = 0; i < held_cnt; i++) held_bytes[i] = seq_buf[pos + i];

        if (eos) begin
            held_cnt = 0;
            lead_off = '0;
            stream_head = 1'b1;
        end

        if (nfound > 0) found[nfound - 1].last = 1'b1;
        for (i = 0; i < nfound; i++) decoded_q.insert(decoded_q.size(), found[i]);
    endtask

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    //------------------------------------------------------------------
    // Sender side. Called at a falling edge; returns at the falling edge
    // after the word went through, with valid still high so a following
    // word can go back to back.
    //------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic eos);
        if (idle_on && $urandom_range(0, 99) < gap_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_in_byte       = b;
        s_end_of_stream = eos;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_decode(b, eos);
        words_sent++;
        @(negedge aclk);
    endtask

    // Sends the first k bytes of seq (MSB byte first); eos on the last one if eos_last is set.
    task automatic send_bytes(input logic [31:0] seq, input int k, input bit eos_last);
        int i;
        for (i = 0; i < k; i++)
            send_word(seq[31 - 8 * i -: 8], (i == k - 1) && eos_last);
    endtask

    // UTF-8 form of cp at a chosen length; a length too big for cp gives an
    // overlong form.
    function automatic logic [31:0] utf8_encode(input int len, input logic [20:0] cp);
        case (len)
            1: return {cp[7:0], 24'h0};
            2: return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
            3: return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
            default: return {5'b11110, cp[20:18], 2'b10, cp[17:12],
                             2'b10, cp[11:6], 2'b10, cp[5:0]};
        endcase
    endfunction

    // Sender stops and waits until every owed result has come back.
    task automatic wait_drained();
        s_valid = 1'b0;
        while (decoded_q.size() != 0) @(negedge aclk);
    endtask

    //------------------------------------------------------------------
    // Receiver side: m_ready drops for random bursts.
    //------------------------------------------------------------------
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = 1'b1;
            if (idle_on && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 14);
        end
    end

    // Scoreboard: every result word is matched against the oldest expectation.
    always @(posedge aclk) begin : check_results
        exp_word_t w;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (decoded_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected word kind %0d cp %h offset %0d",
                                        m_kind, m_code_point, m_byte_offset));
            end else begin
                w = decoded_q.pop_front();
                if (m_kind !== w.kind)
                    flag_mismatch($sformatf("kind %0d, want %0d (offset %0d)",
                                            m_kind, w.kind, w.off));
                if (m_code_point !== w.cp)
                    flag_mismatch($sformatf("code point %h, want %h (offset %0d)",
                                            m_code_point, w.cp, w.off));
                if (m_byte_offset !== w.off)
                    flag_mismatch($sformatf("offset %0d, want %0d",
                                            m_byte_offset, w.off));
                if (m_last_result !== w.last)
                    flag_mismatch($sformatf("last flag %b, want %b (offset %0d)",
                                            m_last_result, w.last, w.off));
            end
        end
    end

    // Watchdog on stretches where no word moves on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // Directed tests
    //------------------------------------------------------------------

    // BOM right after reset is dropped but still counts toward the offset;
    // the same three bytes mid-stream decode to U+FEFF.
    task automatic test_bom_handling();
        send_bytes(32'hEFBBBF00, 3, 1'b0);
        send_word(8'h41, 1'b1);
        send_word(8'h41, 1'b0);
        send_bytes(32'hEFBBBF00, 3, 1'b0);
    endtask

    // One of each error kind, with the re-scan of bytes after a dropped lead.
    task automatic test_error_kinds();
        send_bytes(32'hC0800000, 2, 1'b0);   // overlong, then stray continuation
        send_bytes(32'hF0808080, 4, 1'b0);   // overlong 4-byte: four results at once
        send_word(8'hF8, 1'b0);              // invalid leads
        send_word(8'hFF, 1'b0);
        send_bytes(32'hE2410000, 2, 1'b0);   // missing continuation, 'A' re-read
        send_bytes(32'hE2820000, 2, 1'b1);   // cut short by end of stream
    endtask

    // Field extremes: lowest and highest one-byte values, largest 21-bit value.
    task automatic test_extremes();
        send_word(8'h00, 1'b0);
        send_word(8'h7F, 1'b0);
        send_bytes(32'hF7BFBFBF, 4, 1'b1);
    endtask

    //------------------------------------------------------------------
    // Random traffic: mostly well-formed characters of random length and
    // value, mixed with overlong forms, truncated sequences, stray
    // continuations and arbitrary bytes. Streams end at random.
    //------------------------------------------------------------------
    task automatic run_random_words(input int target);
        int          stop_at;
        int          next_knobs;
        int          pick;
        int          len;
        int          k;
        bit          eos_last;
        bit          at_head;
        logic [20:0] cp;
        logic [31:0] seq;

        stop_at = words_sent + target;
        next_knobs = words_sent;
        at_head = 1'b0;
        while (words_sent < stop_at) begin
            // new idling profile every ~40 words; some phases run clean
            if (words_sent >= next_knobs) begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                next_knobs = words_sent + 40;
            end

            if (at_head && $urandom_range(0, 3) == 0)
                send_bytes(32'hEFBBBF00, 3, 1'b0);

            eos_last = ($urandom_range(0, 99) < 7);
            pick = $urandom_range(0, 99);
            len = $urandom_range(1, 4);
            case (len)
                1: cp = 21'($urandom_range(0, 'h7F));
                2: cp = 21'($urandom_range('h80, 'h7FF));
                3: cp = 21'($urandom_range('h800, 'hFFFF));
                default: cp = 21'($urandom_range('h10000, 'h1FFFFF));
            endcase
            k = len;
            if (pick < 72) begin
                seq = utf8_encode(len, cp);
            end else if (pick < 80) begin
                len = $urandom_range(2, 4);
                cp = (len == 2) ? 21'($urandom_range(0, 'h7F)) :
                     (len == 3) ? 21'($urandom_range(0, 'h7FF)) :
                                  21'($urandom_range(0, 'hFFFF));
                seq = utf8_encode(len, cp);
                k = len;
            end else if (pick < 88) begin
                len = $urandom_range(2, 4);
                seq = utf8_encode(len, cp);
                k = $urandom_range(1, len - 1);
            end else if (pick < 94) begin
                seq = {2'b10, 6'($urandom_range(0, 63)), 24'h0};
                k = 1;
            end else begin
                seq = {8'($urandom_range(0, 255)), 24'h0};
                k = 1;
            end
            send_bytes(seq, k, eos_last);
            at_head = eos_last;
        end
    endtask

    task automatic test_random_streams();
        run_random_words(120);
    endtask

    // Sender holds off until the decoder has delivered everything owed,
    // then restarts traffic from an idle pipeline.
    task automatic test_pause_and_resume();
        wait_drained();
        @(negedge aclk);
        run_random_words(120);
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_full_rate();
        idle_on = 1'b0;
        stall_left = 0;
        run_random_words(60);
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_bom_handling();
        test_error_kinds();
        test_extremes();
        test_random_streams();
        test_pause_and_resume();
        test_full_rate();

        // drain, then give the decoder time to show any extra word
        wait_drained();
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
